>>> rtl/svm_pkg.sv
// shared types and constants for the stack machine execute unit
package svm_pkg;

    // default sizes
    localparam int unsigned STACK_DEPTH_DEF = 1024;
    localparam int unsigned REG_COUNT_DEF   = 10;
    localparam int unsigned PC_WIDTH_DEF    = 16;
    localparam int unsigned Q_DEPTH         = 2;
    localparam logic [15:0] PROG_LEN_RESET  = 16'd2;

    // decoded operation codes
    typedef enum logic [3:0] {
        OP_PUSH   = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_JUMP   = 4'd3,
        OP_POP    = 4'd4,
        OP_JLT    = 4'd5,
        OP_JGT    = 4'd6,
        OP_INC    = 4'd7,
        OP_DEC    = 4'd8,
        OP_SELECT = 4'd9,
        OP_STORE  = 4'd10,
        OP_ADDREG = 4'd11,
        OP_SUBREG = 4'd12,
        OP_NOP    = 4'd13
    } t_op;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_FEW    = 3'd2,
        ST_SEGV   = 3'd3,
        ST_BADTGT = 3'd4,
        ST_NOREG  = 3'd5,
        ST_OVF    = 3'd6
    } t_status;

    // back end sequencer states
    typedef enum logic {
        S_EXEC = 1'b0,
        S_READ = 1'b1
    } t_state;

    // classified instruction between front and back
    typedef struct packed {
        t_op         op;
        logic [63:0] operand;
    } t_item;

    // one result transaction
    typedef struct packed {
        t_status     status;
        logic [15:0] next_pc;
        logic [10:0] stack_depth;
        logic [63:0] top_value;
        logic [31:0] selected_reg_value;
    } t_result;

endpackage

>>> rtl/svm_fifo.sv
// small register queue used between the parts of the execute unit
module svm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = svm_pkg::Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill updates
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/svm_front.sv
// front end: accepts instructions, classifies the opcode and queues them
module svm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [3:0]    i_kind,
    input  logic [63:0]   i_operand,
    output logic          o_full,
    input  logic          i_pop,
    output svm_pkg::t_item o_item,
    output logic          o_empty
);
    svm_pkg::t_item item_in;
    svm_pkg::t_op   op;

    // opcode classification, unused codes become no-ops
    always_comb begin
        case (i_kind)
            4'd0:    op = svm_pkg::OP_PUSH;
            4'd1:    op = svm_pkg::OP_ADD;
            4'd2:    op = svm_pkg::OP_SUB;
            4'd3:    op = svm_pkg::OP_JUMP;
            4'd4:    op = svm_pkg::OP_POP;
            4'd5:    op = svm_pkg::OP_JLT;
            4'd6:    op = svm_pkg::OP_JGT;
            4'd7:    op = svm_pkg::OP_INC;
            4'd8:    op = svm_pkg::OP_DEC;
            4'd9:    op = svm_pkg::OP_SELECT;
            4'd10:   op = svm_pkg::OP_STORE;
            4'd11:   op = svm_pkg::OP_ADDREG;
            4'd12:   op = svm_pkg::OP_SUBREG;
            default: op = svm_pkg::OP_NOP;
        endcase
        item_in.op      = op;
        item_in.operand = i_operand;
    end

    // decoupling queue towards the back end
    svm_fifo #(
        .WIDTH ($bits(svm_pkg::t_item)),
        .DEPTH (svm_pkg::Q_DEPTH)
    ) u_iq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (item_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

>>> rtl/svm_back.sv
// back end: executes instructions against the stack memory and registers
module svm_back #(
    parameter int unsigned STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF,
    parameter int unsigned REG_COUNT   = svm_pkg::REG_COUNT_DEF,
    parameter int unsigned PC_WIDTH    = svm_pkg::PC_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  svm_pkg::t_item   i_item,
    input  logic             i_item_valid,
    output logic             o_item_pop,
    input  logic [15:0]      i_prog_len,
    input  logic             i_res_full,
    output logic             o_res_push,
    output svm_pkg::t_result o_res
);
    localparam int unsigned AW  = $clog2(STACK_DEPTH);
    localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned RSW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    svm_pkg::t_state r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [PC_WIDTH-1:0] r_pc, n_pc, step_pc;
    logic [63:0]         r_top, n_top;
    logic [31:0]         r_regs [REG_COUNT];
    logic [31:0]         n_regs [REG_COUNT];
    logic [RSW-1:0]      r_sel, n_sel;
    svm_pkg::t_op        r_op;
    logic [63:0]         r_opnd;
    logic [AW-1:0]       r_addr;
    logic [63:0]         r_rd;
    logic [63:0]         r_stack [STACK_DEPTH];

    logic                take, go_rd, emit;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_wa, mem_ra, addr_m1, addr_m2;
    logic [63:0]         mem_wd, val;
    svm_pkg::t_status    status;
    logic                below;
    logic [PC_WIDTH+15:0] pc_ext;
    logic [CW+10:0]      cnt_ext;

    assign take       = (r_state == svm_pkg::S_EXEC) && i_item_valid && !i_res_full;
    assign o_item_pop = take;
    assign step_pc    = r_pc + 1'b1;
    assign addr_m1    = AW'(r_cnt - CW'(1));
    assign addr_m2    = AW'(r_cnt - CW'(2));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            svm_pkg::S_EXEC: if (take && go_rd) n_state = svm_pkg::S_READ;
            svm_pkg::S_READ: if (!i_res_full) n_state = svm_pkg::S_EXEC;
            default:         n_state = svm_pkg::S_EXEC;
        endcase
    end

    // execution datapath and outputs
    always_comb begin
        n_cnt  = r_cnt;
        n_pc   = r_pc;
        n_top  = r_top;
        n_regs = r_regs;
        n_sel  = r_sel;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = addr_m2;
        mem_ra = addr_m2;
        mem_wd = r_opnd;
        status = svm_pkg::ST_OK;
        go_rd  = 1'b0;
        emit   = 1'b0;
        val    = '0;
        below  = 1'b0;
        if (take) begin
            case (i_item.op)
                svm_pkg::OP_PUSH: begin
                    if (r_cnt == CW'(STACK_DEPTH)) begin
                        status = svm_pkg::ST_OVF;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = AW'(r_cnt);
                        mem_wd = i_item.operand;
                        n_top  = i_item.operand;
                        n_cnt  = r_cnt + 1'b1;
                        n_pc   = step_pc;
                    end
                end
                svm_pkg::OP_ADD, svm_pkg::OP_SUB: begin
                    if (r_cnt < CW'(2)) begin
                        status = svm_pkg::ST_FEW;
                    end else begin
                        mem_re = 1'b1;
                        go_rd  = 1'b1;
                    end
                end
                svm_pkg::OP_JUMP: begin
                    if (i_item.operand > 64'(r_pc)) begin
                        status = svm_pkg::ST_SEGV;
                    end else begin
                        n_pc = i_item.operand[PC_WIDTH-1:0];
                    end
                end
                svm_pkg::OP_POP: begin
                    if (r_cnt == '0) begin
                        status = svm_pkg::ST_EMPTY;
                    end else if (r_cnt == CW'(1)) begin
                        n_cnt = '0;
                        n_pc  = step_pc;
                    end else begin
                        mem_re = 1'b1;
                        go_rd  = 1'b1;
                    end
                end
                svm_pkg::OP_JLT, svm_pkg::OP_JGT: begin
                    if (i_item.operand >= 64'(i_prog_len)) begin
                        status = svm_pkg::ST_BADTGT;
                    end else if (r_cnt < CW'(2)) begin
                        status = svm_pkg::ST_FEW;
                    end else begin
                        mem_re = 1'b1;
                        go_rd  = 1'b1;
                    end
                end
                svm_pkg::OP_INC, svm_pkg::OP_DEC: begin
                    if (i_item.operand >= 64'(r_cnt)) begin
                        status = svm_pkg::ST_SEGV;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = i_item.operand[AW-1:0];
                        go_rd  = 1'b1;
                    end
                end
                svm_pkg::OP_SELECT: begin
                    if (i_item.operand >= 64'(REG_COUNT)) begin
                        status = svm_pkg::ST_NOREG;
                    end else begin
                        n_sel = i_item.operand[RSW-1:0];
                        n_pc  = step_pc;
                    end
                end
                svm_pkg::OP_STORE: begin
                    n_regs[r_sel] = i_item.operand[31:0];
                    n_pc          = step_pc;
                end
                svm_pkg::OP_ADDREG: begin
                    n_regs[r_sel] = r_regs[r_sel] + i_item.operand[31:0];
                    n_pc          = step_pc;
                end
                svm_pkg::OP_SUBREG: begin
                    n_regs[r_sel] = r_regs[r_sel] - i_item.operand[31:0];
                    n_pc          = step_pc;
                end
                default: begin
                end
            endcase
            emit = !go_rd;
        end else if (r_state == svm_pkg::S_READ && !i_res_full) begin
            // read state: memory data is in r_rd
            emit = 1'b1;
            case (r_op)
                svm_pkg::OP_ADD, svm_pkg::OP_SUB: begin
                    val    = (r_op == svm_pkg::OP_ADD) ? r_rd + r_top : r_rd - r_top;
                    mem_we = 1'b1;
                    mem_wa = addr_m2;
                    mem_wd = val;
                    n_top  = val;
                    n_cnt  = r_cnt - 1'b1;
                    n_pc   = step_pc;
                end
                svm_pkg::OP_POP: begin
                    n_top = r_rd;
                    n_cnt = r_cnt - 1'b1;
                    n_pc  = step_pc;
                end
                svm_pkg::OP_JLT, svm_pkg::OP_JGT: begin
                    below = (r_op == svm_pkg::OP_JLT) ? (r_rd < r_top) : (r_rd > r_top);
                    n_pc  = below ? r_opnd[PC_WIDTH-1:0] : step_pc;
                end
                svm_pkg::OP_INC, svm_pkg::OP_DEC: begin
                    val    = (r_op == svm_pkg::OP_INC) ? r_rd + 64'd1 : r_rd - 64'd1;
                    mem_we = 1'b1;
                    mem_wa = r_addr;
                    mem_wd = val;
                    if (r_addr == addr_m1) n_top = val;
                    n_pc   = step_pc;
                end
                default: begin
                end
            endcase
        end
        o_res_push = emit;
        pc_ext     = {16'b0, n_pc};
        cnt_ext    = {11'b0, n_cnt};
        o_res.status             = status;
        o_res.next_pc            = pc_ext[15:0];
        o_res.stack_depth        = cnt_ext[10:0];
        o_res.top_value          = (n_cnt != '0) ? n_top : 64'd0;
        o_res.selected_reg_value = n_regs[n_sel];
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svm_pkg::S_EXEC;
            r_cnt   <= '0;
            r_pc    <= '0;
            r_sel   <= '0;
            for (int i = 0; i < int'(REG_COUNT); i++) r_regs[i] <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pc    <= n_pc;
            r_sel   <= n_sel;
            r_regs  <= n_regs;
        end
    end

    // top cache and latched instruction
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (take) begin
            r_op   <= i_item.op;
            r_opnd <= i_item.operand;
            r_addr <= mem_ra;
        end
    end

    // stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_stack[mem_wa] <= mem_wd;
        if (mem_re) r_rd <= r_stack[mem_ra];
    end

endmodule

>>> rtl/stack_vm_execute_unit.sv
// top level of the stack machine execute unit
//
// Instructions enter through a queue port: push with kind and operand is
// taken at a rising edge with push high and full low. Results leave through
// a queue port: while empty is low the oldest result is on the o_ ports and
// it is taken at an edge with pop high. program_length is written through
// i_cfg_we / i_cfg_data; the user must write it only while the unit is idle,
// which the block itself does not enforce. An instruction that needs a
// stack entry from memory (add, sub, jlt, jgt, inc, dec, and pop with more
// than one entry) passes through S_READ, since the stack memory has a
// registered read; no new instruction is taken there. The front queue
// keeps accepting while the back end works.
// Synchronous active-low reset empties both queues, clears the stack count,
// pc, registers and selection, and sets program_length to 2. The stack
// memory itself is not cleared. A stalled receiver fills the result queue;
// the back end then holds and the front queue fills and raises full.
module stack_vm_execute_unit #(
    parameter int unsigned STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF,
    parameter int unsigned REG_COUNT   = svm_pkg::REG_COUNT_DEF,
    parameter int unsigned PC_WIDTH    = svm_pkg::PC_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  i_kind,
    input  logic [63:0] i_operand,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [15:0] o_next_pc,
    output logic [10:0] o_stack_depth,
    output logic [63:0] o_top_value,
    output logic signed [31:0] o_selected_reg_value,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    svm_pkg::t_item   item;
    svm_pkg::t_result res_in, res_out;
    logic             item_empty, item_pop, res_full, res_push;
    logic [15:0]      r_prog_len;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= svm_pkg::PROG_LEN_RESET;
        end else if (i_cfg_we) begin
            r_prog_len <= i_cfg_data;
        end
    end

    // front end
    svm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_kind    (i_kind),
        .i_operand (i_operand),
        .o_full    (full),
        .i_pop     (item_pop),
        .o_item    (item),
        .o_empty   (item_empty)
    );

    // back end
    svm_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .REG_COUNT   (REG_COUNT),
        .PC_WIDTH    (PC_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (!item_empty),
        .o_item_pop   (item_pop),
        .i_prog_len   (r_prog_len),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // result queue
    svm_fifo #(
        .WIDTH ($bits(svm_pkg::t_result)),
        .DEPTH (svm_pkg::Q_DEPTH)
    ) u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_status             = res_out.status;
    assign o_next_pc            = res_out.next_pc;
    assign o_stack_depth        = res_out.stack_depth;
    assign o_top_value          = res_out.top_value;
    assign o_selected_reg_value = res_out.selected_reg_value;

    // checks
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_status <= svm_pkg::ST_OVF)
        else $error("result status out of range");

    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (STACK_DEPTH < 2048) && !empty && (o_stack_depth == 11'd0) |-> o_top_value == 64'd0)
        else $error("top value not zero on empty stack");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_full |-> !res_push)
        else $error("result pushed into full queue");

endmodule

>>> test/tb.sv
// self-checking testbench for the stack machine execute unit
`timescale 1ns / 1ps

module tb;

    localparam int unsigned DEPTH      = 1024;
    localparam int unsigned NREG       = 10;
    localparam int unsigned ITEMS      = 1950;
    localparam int unsigned LIMIT      = 400000;
    localparam int unsigned HOLD_LEN   = 300;
    localparam int unsigned DRAIN_LEN  = 16;
    localparam int unsigned N_DIRECTED = 24;
    localparam int unsigned DRAIN_POPS = 250;
    localparam int unsigned TAIL_ITEMS = 20;
    localparam int unsigned RAND_PHASE =
        (ITEMS - N_DIRECTED - (DEPTH + 5) - DRAIN_POPS - TAIL_ITEMS) / 5;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] operand;
    } t_instr;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [3:0]  i_kind;
    logic [63:0] i_operand;
    logic        empty;
    logic        pop;
    logic [2:0]  o_status;
    logic [15:0] o_next_pc;
    logic [10:0] o_stack_depth;
    logic [63:0] o_top_value;
    logic signed [31:0] o_selected_reg_value;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    stack_vm_execute_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_kind(i_kind), .i_operand(i_operand),
        .empty(empty), .pop(pop),
        .o_status(o_status), .o_next_pc(o_next_pc), .o_stack_depth(o_stack_depth),
        .o_top_value(o_top_value), .o_selected_reg_value(o_selected_reg_value),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // predicted machine state
    logic [63:0] mdl_stack [DEPTH];
    int unsigned mdl_count;
    logic [15:0] mdl_pc;
    logic [31:0] mdl_regs [NREG];
    int unsigned mdl_sel;
    logic [15:0] mdl_prog_len;

    t_instr  pending_instrs [$];
    svm_pkg::t_result expected_results [$];
    int unsigned fail_count;
    int unsigned cycle_count;
    bit          stim_done;
    int unsigned hold_cycles;
    bit          hold_req;
    bit          drv_pause;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // execute one instruction on the predicted state
    function automatic svm_pkg::t_result exec_instr(t_instr ins);
        svm_pkg::t_result r;
        svm_pkg::t_status st;
        logic [15:0] step_pc;
        logic [63:0] a, b;
        st      = svm_pkg::ST_OK;
        step_pc = mdl_pc + 16'd1;
        case (ins.kind)
            svm_pkg::OP_PUSH: begin
                if (mdl_count >= DEPTH) st = svm_pkg::ST_OVF;
                else begin
                    mdl_stack[mdl_count] = ins.operand;
                    mdl_count++;
                    mdl_pc = step_pc;
                end
            end
            svm_pkg::OP_ADD, svm_pkg::OP_SUB: begin
                if (mdl_count < 2) st = svm_pkg::ST_FEW;
                else begin
                    a = mdl_stack[mdl_count-2];
                    b = mdl_stack[mdl_count-1];
                    mdl_stack[mdl_count-2] = (ins.kind == svm_pkg::OP_ADD) ? a + b : a - b;
                    mdl_count--;
                    mdl_pc = step_pc;
                end
            end
            svm_pkg::OP_JUMP: begin
                if (ins.operand > {48'd0, mdl_pc}) st = svm_pkg::ST_SEGV;
                else mdl_pc = ins.operand[15:0];
            end
            svm_pkg::OP_POP: begin
                if (mdl_count == 0) st = svm_pkg::ST_EMPTY;
                else begin
                    mdl_count--;
                    mdl_pc = step_pc;
                end
            end
            svm_pkg::OP_JLT, svm_pkg::OP_JGT: begin
                if (ins.operand >= {48'd0, mdl_prog_len}) st = svm_pkg::ST_BADTGT;
                else if (mdl_count < 2) st = svm_pkg::ST_FEW;
                else begin
                    a = mdl_stack[mdl_count-2];
                    b = mdl_stack[mdl_count-1];
                    if ((ins.kind == svm_pkg::OP_JLT) ? (a < b) : (a > b))
                        mdl_pc = ins.operand[15:0];
                    else mdl_pc = step_pc;
                end
            end
            svm_pkg::OP_INC, svm_pkg::OP_DEC: begin
                if (ins.operand >= 64'(mdl_count)) st = svm_pkg::ST_SEGV;
                else begin
                    if (ins.kind == svm_pkg::OP_INC) mdl_stack[ins.operand[9:0]] += 64'd1;
                    else mdl_stack[ins.operand[9:0]] -= 64'd1;
                    mdl_pc = step_pc;
                end
            end
            svm_pkg::OP_SELECT: begin
                if (ins.operand >= 64'(NREG)) st = svm_pkg::ST_NOREG;
                else begin
                    mdl_sel = ins.operand[31:0];
                    mdl_pc = step_pc;
                end
            end
            svm_pkg::OP_STORE: begin
                mdl_regs[mdl_sel] = ins.operand[31:0];
                mdl_pc = step_pc;
            end
            svm_pkg::OP_ADDREG: begin
                mdl_regs[mdl_sel] += ins.operand[31:0];
                mdl_pc = step_pc;
            end
            svm_pkg::OP_SUBREG: begin
                mdl_regs[mdl_sel] -= ins.operand[31:0];
                mdl_pc = step_pc;
            end
            default: ;
        endcase
        r.status             = st;
        r.next_pc            = mdl_pc;
        r.stack_depth        = mdl_count[10:0];
        r.top_value          = (mdl_count > 0) ? mdl_stack[mdl_count-1] : 64'd0;
        r.selected_reg_value = mdl_regs[mdl_sel];
        return r;
    endfunction

    // mismatch report
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
        fail_count++;
    endtask

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // driver: offers queued items with random gaps, predicts on accept
    int unsigned drv_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push    <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (push && !full) begin
                expected_results.push_back(exec_instr({i_kind, i_operand}));
            end
            if (push && full) begin
                // hold the offered transaction
            end else if (drv_gap != 0) begin
                drv_gap <= drv_gap - 1;
                push    <= 1'b0;
            end else if (pending_instrs.size() != 0 && !drv_pause) begin
                t_instr nx;
                nx = pending_instrs.pop_front();
                i_kind    <= nx.kind;
                i_operand <= nx.operand;
                push      <= 1'b1;
                drv_gap   <= gap_len();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: random pops, long hold-off on request, compares fields
    int unsigned mon_gap;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            pop     <= 1'b0;
            mon_gap <= 0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result transaction (cycle %0d)", cycle_count);
                    fail_count++;
                end else begin
                    svm_pkg::t_result w;
                    w = expected_results.pop_front();
                    if (o_status !== w.status) report("status", o_status, w.status);
                    if (o_next_pc !== w.next_pc) report("next_pc", o_next_pc, w.next_pc);
                    if (o_stack_depth !== w.stack_depth)
                        report("stack_depth", o_stack_depth, w.stack_depth);
                    if (o_top_value !== w.top_value)
                        report("top_value", o_top_value, w.top_value);
                    if (o_selected_reg_value !== w.selected_reg_value)
                        report("selected_reg_value", o_selected_reg_value,
                               w.selected_reg_value);
                end
            end
            if (hold_req && hold_cycles == 0) begin
                hold_cycles <= HOLD_LEN;
                hold_req    <= 1'b0;
                pop         <= 1'b0;
            end else if (hold_cycles != 0) begin
                hold_cycles <= hold_cycles - 1;
                pop         <= 1'b0;
            end else if (mon_gap != 0) begin
                mon_gap <= mon_gap - 1;
                pop     <= 1'b0;
            end else begin
                pop     <= 1'b1;
                mon_gap <= gap_len();
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycle_count > LIMIT) begin
            $display("[stack_vm_execute_unit] ERROR");
            $finish;
        end
    end

    task automatic add_instr(svm_pkg::t_op k, logic [63:0] v);
        pending_instrs.push_back({4'(k), v});
    endtask

    // sampled between edges so that driver updates have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_instrs.size() != 0 || push || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);
    endtask

    task automatic write_prog_len(logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mdl_prog_len = v;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random well-formed-leaning instruction
    task automatic add_random();
        int unsigned p;
        logic [63:0] v;
        p = $urandom_range(99);
        case ($urandom_range(12))
            0: begin
                v = rand64();
                if (p < 30) v = $urandom_range(3) == 0 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(p);
                add_instr(svm_pkg::OP_PUSH, v);
            end
            1: add_instr(svm_pkg::OP_ADD, rand64());
            2: add_instr(svm_pkg::OP_SUB, rand64());
            3: add_instr(svm_pkg::OP_JUMP, p < 80 ? 64'($urandom_range(70000)) : rand64());
            4: add_instr(svm_pkg::OP_POP, rand64());
            5: add_instr(svm_pkg::OP_JLT, p < 80 ? 64'($urandom_range(70000)) : rand64());
            6: add_instr(svm_pkg::OP_JGT, p < 80 ? 64'($urandom_range(70000)) : rand64());
            7: add_instr(svm_pkg::OP_INC, p < 85 ? 64'($urandom_range(40)) : rand64());
            8: add_instr(svm_pkg::OP_DEC, p < 85 ? 64'($urandom_range(40)) : rand64());
            9: add_instr(svm_pkg::OP_SELECT, p < 85 ? 64'($urandom_range(11)) : rand64());
            10: add_instr(svm_pkg::OP_STORE, rand64());
            11: add_instr(svm_pkg::OP_ADDREG, rand64());
            default: begin
                if (p < 90) add_instr(svm_pkg::OP_SUBREG, rand64());
                else pending_instrs.push_back({4'($urandom_range(15, 13)), rand64()});
            end
        endcase
    endtask

    // stimulus
    initial begin
        i_rst_n = 1'b0; push = 1'b0; pop = 1'b0; i_kind = '0; i_operand = '0;
        i_cfg_we = 1'b0; i_cfg_data = '0;
        cycle_count = 0; fail_count = 0; hold_cycles = 0; hold_req = 0; drv_pause = 0;
        mdl_count = 0; mdl_pc = '0; mdl_sel = 0; mdl_prog_len = svm_pkg::PROG_LEN_RESET;
        foreach (mdl_regs[i]) mdl_regs[i] = '0;
        foreach (mdl_stack[i]) mdl_stack[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: errors on empty state, extremes, every operation
        add_instr(svm_pkg::OP_POP, 64'd0);
        add_instr(svm_pkg::OP_ADD, 64'd0);
        add_instr(svm_pkg::OP_JLT, 64'd2);
        add_instr(svm_pkg::OP_JLT, 64'd1);
        add_instr(svm_pkg::OP_INC, 64'd0);
        add_instr(svm_pkg::OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
        add_instr(svm_pkg::OP_PUSH, 64'd1);
        add_instr(svm_pkg::OP_JGT, 64'd1);
        add_instr(svm_pkg::OP_JLT, 64'd0);
        add_instr(svm_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
        add_instr(svm_pkg::OP_DEC, 64'd0);
        add_instr(svm_pkg::OP_INC, 64'd0);
        add_instr(svm_pkg::OP_INC, 64'd1);
        add_instr(svm_pkg::OP_PUSH, 64'd5);
        add_instr(svm_pkg::OP_SUB, 64'd0);
        add_instr(svm_pkg::OP_JUMP, 64'hFFFF_FFFF_FFFF_FFFF);
        add_instr(svm_pkg::OP_JUMP, 64'd3);
        add_instr(svm_pkg::OP_SELECT, 64'd10);
        add_instr(svm_pkg::OP_SELECT, 64'd9);
        add_instr(svm_pkg::OP_STORE, 64'hFFFF_FFFF_8000_0000);
        add_instr(svm_pkg::OP_SUBREG, 64'd1);
        add_instr(svm_pkg::OP_ADDREG, 64'h0000_0001_7FFF_FFFF);
        add_instr(svm_pkg::OP_NOP, 64'hFFFF_FFFF_FFFF_FFFF);
        pending_instrs.push_back({4'd15, 64'd0});
        wait_idle();

        // fill the stack to overflow under a long receiver hold-off
        write_prog_len(16'hFFFF);
        hold_req = 1;
        for (int i = 0; i < DEPTH + 2; i++) add_instr(svm_pkg::OP_PUSH, rand64());
        add_instr(svm_pkg::OP_JGT, 64'hFFFE);
        add_instr(svm_pkg::OP_INC, 64'(DEPTH - 1));
        add_instr(svm_pkg::OP_INC, 64'(DEPTH));
        for (int i = 0; i < DRAIN_POPS; i++) add_instr(svm_pkg::OP_POP, 64'd0);
        wait_idle();

        // random phases across several program lengths
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_prog_len(16'd1);
                1: write_prog_len(16'd0);
                2: write_prog_len(16'hFFFF);
                default: write_prog_len(16'($urandom_range(65535, 1)));
            endcase
            if (ph == 3) hold_req = 1;
            for (int i = 0; i < RAND_PHASE / 2; i++) add_random();
            // sender pauses midway until everything has drained
            @(negedge i_clk);
            while (pending_instrs.size() != 0) @(negedge i_clk);
            drv_pause = 1;
            while (push || expected_results.size() != 0) @(negedge i_clk);
            drv_pause = 0;
            for (int i = RAND_PHASE / 2; i < RAND_PHASE; i++) add_random();
            wait_idle();
        end
        write_prog_len(svm_pkg::PROG_LEN_RESET);
        for (int i = 0; i < TAIL_ITEMS; i++) add_random();
        wait_idle();

        if (fail_count == 0) begin
            $display("[stack_vm_execute_unit] OK");
        end else begin
            $display("[stack_vm_execute_unit] ERROR");
        end
        $finish;
    end
endmodule

>>> stack_vm_execute_unit.f
rtl/svm_pkg.sv
rtl/svm_fifo.sv
rtl/svm_front.sv
rtl/svm_back.sv
rtl/stack_vm_execute_unit.sv
test/tb.sv
